[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the ball velocity estimator.
// No dependencies; the assertions vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising edge outside reset.
`define BVE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an expression never holds at a rising edge outside reset.
`define BVE_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define BVE_ASSERT(lbl, clk, rst, prop, msg)
`define BVE_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

[rtl/bve_pkg.sv]
// Package of the ball velocity estimator: widths, constants, state codes
// and the structs passed between its modules. No dependencies.
package bve_pkg;

   localparam int POS_W     = 20;
   localparam int POS_FRAC  = 4;
   localparam int TIME_W    = 32;
   localparam int OUT_W     = 16;
   localparam int VEL_W     = 24;
   localparam int VEL_FRAC  = 8;
   localparam int ALPHA_W   = 17;
   localparam int ALPHA_FRAC = 16;
   localparam int LIMIT_W   = 4;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;

   // shared multiplier and accumulator
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = 45;
   localparam int ACC_W   = 41;

   // sequential divider
   localparam int DIVIDEND_W = 46;
   localparam int DIVISOR_W  = TIME_W + 1;
   localparam int DIV_CNT_W  = 6;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1) << ALPHA_FRAC;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(19661);
   localparam logic [TIME_W-1:0]  GAP_RESET   = TIME_W'(100000);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);
   localparam logic [LIMIT_W-1:0] MISS_MAX    = {LIMIT_W{1'b1}};
   localparam logic [TIME_W-1:0]  MIN_GAP_US  = TIME_W'(100);

   // Q.4 mm per us to Q.8 mm per s
   localparam logic signed [MUL_B_W-1:0] VEL_SCALE = MUL_B_W'(16000000);

   localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
   localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic [VEL_W-1:0] VEL_HALF  = VEL_W'(1) << (VEL_FRAC - 1);
   localparam logic [ACC_W-1:0] FILT_HALF = ACC_W'(1) << (ALPHA_FRAC - 1);
   localparam logic signed [POS_W-1:0] POS_BIAS = POS_W'((1 << POS_FRAC) - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA      = 2'd0,
      CSR_MAX_GAP    = 2'd1,
      CSR_MISS_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_RAW,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL_NEW,
      ST_MUL_OLD,
      ST_ACC,
      ST_ROUND,
      ST_EMIT_HIT,
      ST_EMIT_LOST
   } seq_state_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic [TIME_W-1:0]  max_gap_us;
      logic [LIMIT_W-1:0] miss_limit;
   } cfg_type;

   typedef struct packed {
      logic                    ball_found;
      logic signed [POS_W-1:0] meas_x;
      logic signed [POS_W-1:0] meas_y;
      logic [TIME_W-1:0]       frame_time;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] pos_x_mm;
      logic signed [OUT_W-1:0] pos_y_mm;
      logic signed [OUT_W-1:0] vel_x_mms;
      logic signed [OUT_W-1:0] vel_y_mms;
      logic                    detected;
   } rsp_payload_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_stat_type;

endpackage

[rtl/bve_req_if.sv]
// Input channel of the ball velocity estimator: one detection item.
// Depends on bve_pkg for field widths.
interface bve_req_if;
   import bve_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    ball_found;
   logic signed [POS_W-1:0] meas_x;
   logic signed [POS_W-1:0] meas_y;
   logic [TIME_W-1:0]       frame_time;

   modport source (output valid, ball_found, meas_x, meas_y, frame_time, input ready);
   modport sink   (input valid, ball_found, meas_x, meas_y, frame_time, output ready);
endinterface

[rtl/bve_rsp_if.sv]
// Result channel of the ball velocity estimator: one published estimate.
// Depends on bve_pkg for field widths.
interface bve_rsp_if;
   import bve_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] pos_x_mm;
   logic signed [OUT_W-1:0] pos_y_mm;
   logic signed [OUT_W-1:0] vel_x_mms;
   logic signed [OUT_W-1:0] vel_y_mms;
   logic                    detected;

   modport source (output valid, pos_x_mm, pos_y_mm, vel_x_mms, vel_y_mms, detected,
                   input ready);
   modport sink   (input valid, pos_x_mm, pos_y_mm, vel_x_mms, vel_y_mms, detected,
                   output ready);
endinterface

[rtl/bve_divider.sv]
// Restoring divider, one quotient bit per cycle, shared by both axes.
// Depends on bve_pkg and assert_macros.svh.
module bve_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  bve_pkg::div_ctrl_type ctrl,
   output bve_pkg::div_stat_type stat
);
   import bve_pkg::*;
   `include "assert_macros.svh"

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;

   logic [DIVISOR_W:0] trial;
   logic [DIVISOR_W:0] diff;
   logic               fits;
   logic               last;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};
      last  = count_ff == DIV_CNT_W'(DIVIDEND_W - 1);

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (ctrl.start && !busy_ff) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = ctrl.dividend;
         div_in   = ctrl.divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

   `BVE_ASSERT(a_div_done_idle, clock, reset, done_ff |-> !busy_ff, "divider done while busy")
   `BVE_ASSERT(a_div_start_runs, clock, reset, (ctrl.start && !busy_ff) |=> busy_ff,
               "divider failed to start")
   `BVE_ASSERT(a_div_rem_below, clock, reset,
               busy_ff |-> ((rem_ff < div_ff) || (div_ff == '0)),
               "divider remainder not below divisor")
endmodule

[rtl/bve_seq.sv]
// Sequencer and datapath of the ball velocity estimator: tracking state,
// shared multiplier, accumulator and rounding. Depends on bve_pkg, the
// divider status struct and assert_macros.svh.
module bve_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  bve_pkg::cfg_type         cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bve_pkg::req_payload_type req_data,
   output logic                     res_push,
   output bve_pkg::rsp_payload_type res_data,
   input  logic                     out_free,
   output bve_pkg::div_ctrl_type    div_ctrl,
   input  bve_pkg::div_stat_type    div_stat
);
   import bve_pkg::*;
   `include "assert_macros.svh"

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic neg, input logic big,
                                                       input logic [VEL_W-2:0] low);
      logic signed [VEL_W-1:0] v;
      v = $signed({1'b0, low});
      if (big) begin
         return neg ? VEL_MIN : VEL_MAX;
      end
      return neg ? -v : v;
   endfunction

   function automatic logic signed [OUT_W-1:0] vel_mm(input logic signed [VEL_W-1:0] f);
      logic [VEL_W-1:0] mag;
      logic [VEL_W-1:0] rnd;
      logic [OUT_W-1:0] q;
      mag = f[VEL_W-1] ? VEL_W'(-f) : VEL_W'(f);
      rnd = mag + VEL_HALF;
      q   = rnd[VEL_W-1:VEL_FRAC];
      if (f[VEL_W-1]) begin
         return q[OUT_W-1] ? OUT_MIN : -$signed(q);
      end
      return q[OUT_W-1] ? OUT_MAX : $signed(q);
   endfunction

   function automatic logic signed [OUT_W-1:0] pos_mm(input logic signed [POS_W-1:0] p);
      logic signed [POS_W-1:0] adj;
      adj = p[POS_W-1] ? p + POS_BIAS : p;
      return $signed(adj[POS_W-1:POS_FRAC]);
   endfunction

   seq_state_type state_ff, state_in;

   // tracking state
   logic signed [POS_W-1:0] prev_x_ff, prev_y_ff;
   logic [TIME_W-1:0]       prev_time_ff;
   logic                    time_known_ff, pos_known_ff, seeded_ff;
   logic signed [VEL_W-1:0] filt_x_ff, filt_y_ff;
   logic [LIMIT_W-1:0]      miss_run_ff;
   logic                    axis_ff;

   // working registers
   req_payload_type          cur_ff;
   logic [TIME_W-1:0]        gap_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [VEL_W-1:0]  raw_ff;

   logic [TIME_W-1:0]  gap;
   logic               dup, usable, lost;
   logic [LIMIT_W-1:0] miss_next;
   logic [ALPHA_W-1:0] alpha_eff, one_minus;
   logic signed [POS_W:0]   dx;
   logic signed [VEL_W-1:0] filt_sel;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_A_W+MUL_B_W-1:0] mul_full;
   logic [PROD_W-1:0]        prod_mag;
   logic signed [VEL_W-1:0]  raw_in;
   logic [ACC_W-1:0]         acc_mag, acc_rnd;
   logic [ACC_W-ALPHA_FRAC-1:0] filt_q;
   logic signed [VEL_W-1:0]  filt_new;

   always_comb begin
      gap    = cur_ff.frame_time - prev_time_ff;
      dup    = time_known_ff && (cur_ff.frame_time == prev_time_ff);
      usable = pos_known_ff && time_known_ff && (gap > MIN_GAP_US) &&
               (gap <= cfg.max_gap_us);
      miss_next = (miss_run_ff == MISS_MAX) ? miss_run_ff : miss_run_ff + 1'b1;
      lost      = miss_next >= cfg.miss_limit;

      alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
      one_minus = ALPHA_ONE - alpha_eff;

      dx = axis_ff ?
           $signed({cur_ff.meas_y[POS_W-1], cur_ff.meas_y}) -
           $signed({prev_y_ff[POS_W-1], prev_y_ff}) :
           $signed({cur_ff.meas_x[POS_W-1], cur_ff.meas_x}) -
           $signed({prev_x_ff[POS_W-1], prev_x_ff});
      filt_sel = axis_ff ? filt_y_ff : filt_x_ff;

      // shared multiplier operand select
      case (state_ff)
         ST_MUL_RAW: begin
            mul_a = $signed({{(MUL_A_W-POS_W-1){dx[POS_W]}}, dx});
            mul_b = VEL_SCALE;
         end
         ST_MUL_NEW: begin
            mul_a = raw_ff;
            mul_b = $signed({{(MUL_B_W-ALPHA_W){1'b0}}, alpha_eff});
         end
         ST_MUL_OLD: begin
            mul_a = filt_sel;
            mul_b = $signed({{(MUL_B_W-ALPHA_W){1'b0}}, one_minus});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_full = mul_a * mul_b;

      prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      raw_in   = sat_vel(prod_ff[PROD_W-1], |div_stat.quotient[DIVIDEND_W-1:VEL_W-1],
                         div_stat.quotient[VEL_W-2:0]);

      acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      acc_rnd  = acc_mag + FILT_HALF;
      filt_q   = acc_rnd[ACC_W-1:ALPHA_FRAC];
      filt_new = sat_vel(acc_ff[ACC_W-1], |filt_q[ACC_W-ALPHA_FRAC-1:VEL_W-1],
                         filt_q[VEL_W-2:0]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (dup) begin
               state_in = ST_IDLE;
            end else if (!cur_ff.ball_found) begin
               state_in = lost ? ST_EMIT_LOST : ST_IDLE;
            end else begin
               state_in = usable ? ST_MUL_RAW : ST_EMIT_HIT;
            end
         end
         ST_MUL_RAW:   state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_stat.done) state_in = ST_MUL_NEW;
         end
         ST_MUL_NEW: state_in = ST_MUL_OLD;
         ST_MUL_OLD: state_in = ST_ACC;
         ST_ACC:     state_in = ST_ROUND;
         ST_ROUND:   state_in = axis_ff ? ST_EMIT_HIT : ST_MUL_RAW;
         ST_EMIT_HIT, ST_EMIT_LOST: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready         = state_ff == ST_IDLE;
      div_ctrl.start    = state_ff == ST_DIV_START;
      div_ctrl.dividend = {1'b0, prod_mag[PROD_W-2:0], 1'b0} +
                          {{(DIVIDEND_W-TIME_W){1'b0}}, gap_ff};
      div_ctrl.divisor  = {gap_ff, 1'b0};
      res_push          = ((state_ff == ST_EMIT_HIT) || (state_ff == ST_EMIT_LOST)) &&
                          out_free;
      res_data          = '0;
      if (state_ff == ST_EMIT_HIT) begin
         res_data.pos_x_mm  = pos_mm(cur_ff.meas_x);
         res_data.pos_y_mm  = pos_mm(cur_ff.meas_y);
         res_data.vel_x_mms = vel_mm(filt_x_ff);
         res_data.vel_y_mms = vel_mm(filt_y_ff);
         res_data.detected  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_time_ff  <= '0;
         time_known_ff <= 1'b0;
         pos_known_ff  <= 1'b0;
         seeded_ff     <= 1'b0;
         filt_x_ff     <= '0;
         filt_y_ff     <= '0;
         miss_run_ff   <= '0;
         axis_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_CHECK: begin
               if (!dup) begin
                  prev_time_ff  <= cur_ff.frame_time;
                  time_known_ff <= 1'b1;
                  axis_ff       <= 1'b0;
                  if (cur_ff.ball_found) begin
                     miss_run_ff <= '0;
                  end else begin
                     miss_run_ff <= miss_next;
                     if (lost) begin
                        pos_known_ff <= 1'b0;
                        seeded_ff    <= 1'b0;
                     end
                  end
               end
            end
            ST_ROUND: begin
               if (axis_ff) begin
                  filt_y_ff <= filt_new;
                  seeded_ff <= 1'b1;
               end else begin
                  filt_x_ff <= filt_new;
               end
               axis_ff <= ~axis_ff;
            end
            ST_EMIT_HIT: begin
               if (out_free) begin
                  prev_x_ff    <= cur_ff.meas_x;
                  prev_y_ff    <= cur_ff.meas_y;
                  pos_known_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) cur_ff <= req_data;
         end
         ST_CHECK:   gap_ff  <= gap;
         ST_MUL_RAW: prod_ff <= mul_full[PROD_W-1:0];
         ST_MUL_NEW: prod_ff <= mul_full[PROD_W-1:0];
         ST_MUL_OLD: begin
            acc_ff  <= prod_ff[ACC_W-1:0];
            prod_ff <= mul_full[PROD_W-1:0];
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) raw_ff <= raw_in;
         end
         ST_ACC: begin
            if (seeded_ff) acc_ff <= acc_ff + prod_ff[ACC_W-1:0];
         end
         default: ;
      endcase
   end

   `BVE_ASSERT(a_seeded_needs_pos, clock, reset, seeded_ff |-> pos_known_ff,
               "filter seeded without a known position")
   `BVE_ASSERT(a_pos_needs_time, clock, reset, pos_known_ff |-> time_known_ff,
               "position known without a known time")
   `BVE_ASSERT_NEVER(a_start_busy, clock, reset, div_ctrl.start && div_stat.busy,
                     "divider started while busy")
   `BVE_ASSERT(a_done_in_wait, clock, reset, div_stat.done |-> (state_ff == ST_DIV_WAIT),
               "divider finished outside the wait step")
endmodule

[rtl/ball_velocity_estimator.sv]
// Ball velocity estimator: position and smoothed finite-difference velocity per frame.
// An item with a usable frame gap runs the 46-step shared divider once per axis and is
// then published from the EMIT_HIT state; any other item goes from CHECK to EMIT_HIT or
// EMIT_LOST, or publishes nothing. A new item is taken only once the last one is done.
// A finished result waits in the output register while the next item is taken. Synchronous
// reset clears tracking state and loads the defaults (alpha 19661, gap 100000 us, limit 5).
module ball_velocity_estimator (
   input  logic                        clock,
   input  logic                        reset,
   bve_req_if.sink                     req_chan,
   bve_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic [bve_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bve_pkg::CSR_W-1:0]   csr_wdata
);
   import bve_pkg::*;

   // configuration registers
   logic [ALPHA_W-1:0] alpha_ff;
   logic [TIME_W-1:0]  max_gap_ff;
   logic [LIMIT_W-1:0] limit_ff;
   cfg_type            cfg;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   req_payload_type req_data;
   rsp_payload_type res_data;
   logic            res_push;
   logic            out_free;
   logic            seq_ready;
   div_ctrl_type    div_ctrl;
   div_stat_type    div_stat;

   // Take register writes at any time; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff   <= ALPHA_RESET;
         max_gap_ff <= GAP_RESET;
         limit_ff   <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHA:      alpha_ff   <= csr_wdata[ALPHA_W-1:0];
            CSR_MAX_GAP:    max_gap_ff <= csr_wdata[TIME_W-1:0];
            CSR_MISS_LIMIT: limit_ff   <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.alpha      = alpha_ff;
   assign cfg.max_gap_us = max_gap_ff;
   assign cfg.miss_limit = limit_ff;

   // Gather the input item fields for the sequencer.
   assign req_data.ball_found = req_chan.ball_found;
   assign req_data.meas_x     = req_chan.meas_x;
   assign req_data.meas_y     = req_chan.meas_y;
   assign req_data.frame_time = req_chan.frame_time;
   assign req_chan.ready      = seq_ready;

   // The output register is free when empty or being drained this cycle;
   // the sequencer holds its result step until then.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the payload only on a push; hold it while the item waits.
   always_ff @(posedge clock) begin
      if (res_push) rsp_data_ff <= res_data;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pos_x_mm  = rsp_data_ff.pos_x_mm;
   assign rsp_chan.pos_y_mm  = rsp_data_ff.pos_y_mm;
   assign rsp_chan.vel_x_mms = rsp_data_ff.vel_x_mms;
   assign rsp_chan.vel_y_mms = rsp_data_ff.vel_y_mms;
   assign rsp_chan.detected  = rsp_data_ff.detected;

   // Sequencer: tracking state, shared multiplier, filter accumulate and rounding.
   bve_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_chan.valid),
      .req_ready (seq_ready),
      .req_data  (req_data),
      .res_push  (res_push),
      .res_data  (res_data),
      .out_free  (out_free),
      .div_ctrl  (div_ctrl),
      .div_stat  (div_stat)
   );

   // Divider for the raw velocity, displacement over frame gap, rounded.
   bve_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );
endmodule

[bench/tb_ball_velocity_estimator.sv]
// Self-checking bench for ball_velocity_estimator: random and directed detection frames,
// predicted in-line and compared field by field. Depends on bve_pkg, bve_req_if, bve_rsp_if.
module tb_ball_velocity_estimator;
   import bve_pkg::*;

   localparam int POS_MAX         = 524287;
   localparam int POS_MIN         = -524288;
   localparam int SETTLE_CYCLES   = 160;   // longer than the path of one item through the block
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   bve_req_if req_if();
   bve_rsp_if rsp_if();

   ball_velocity_estimator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies held by the predictor
   logic [ALPHA_W-1:0] alpha_cfg;
   logic [TIME_W-1:0]  gap_limit;
   logic [LIMIT_W-1:0] lost_after;

   // Tracking state held by the predictor
   logic signed [POS_W-1:0] last_x, last_y;
   logic [TIME_W-1:0]       last_time;
   bit                      time_seen, pos_seen, seeded;
   logic signed [VEL_W-1:0] vel_fx, vel_fy;
   logic [LIMIT_W-1:0]      misses;

   rsp_payload_type pending_estimates[$];
   int failures;
   int idle_cycles;
   bit idle_on;
   int hold_off_reqs;   // bumped by a test that wants a long hold-off
   int hold_off_seen;   // requests already served by the receiver
   int hold_left;
   int stall_left;

   // Stimulus trajectory, kept apart from the predictor
   logic [TIME_W-1:0] track_time;
   int track_x, track_y;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Arithmetic of the estimator
   // ---------------------------------------------------------------------------------

   // Divide, rounding half away from zero; den is positive.
   function automatic longint round_div(input longint num, input longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clamp_vel(input longint v);
      if (v > longint'(VEL_MAX)) return longint'(VEL_MAX);
      if (v < longint'(VEL_MIN)) return longint'(VEL_MIN);
      return v;
   endfunction

   // Fold one raw sample into the moving average; unseeded means alpha times raw.
   function automatic longint ema_axis(input longint filt, input longint raw, input longint a,
                                       input bit was_seeded);
      longint acc;
      acc = a * raw;
      if (was_seeded)
         acc += (longint'(65536) - a) * filt;
      return clamp_vel(round_div(acc, 65536));
   endfunction

   function automatic logic signed [OUT_W-1:0] vel_to_out(input logic signed [VEL_W-1:0] f);
      longint v;
      v = round_div(longint'(f), 256);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return OUT_W'(v);
   endfunction

   // Q.4 to whole millimetres, truncating toward zero
   function automatic logic signed [OUT_W-1:0] pos_to_out(input logic signed [POS_W-1:0] q4);
      return OUT_W'(int'(q4) / 16);
   endfunction

   // Work out what one accepted frame publishes, if anything, and advance the state.
   function automatic void estimate_frame(input req_payload_type f);
      rsp_payload_type  est;
      logic [TIME_W-1:0] gap;
      longint a, rx, ry;
      if (time_seen && f.frame_time == last_time)
         return;   // repeated stamp: drop the frame
      if (f.ball_found) begin
         misses = '0;
         if (pos_seen && time_seen) begin
            gap = f.frame_time - last_time;
            if (gap > MIN_GAP_US && gap <= gap_limit) begin
               a  = (alpha_cfg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_cfg);
               rx = clamp_vel(round_div((longint'(f.meas_x) - longint'(last_x)) * 16000000,
                                        longint'(gap)));
               ry = clamp_vel(round_div((longint'(f.meas_y) - longint'(last_y)) * 16000000,
                                        longint'(gap)));
               vel_fx = VEL_W'(ema_axis(longint'(vel_fx), rx, a, seeded));
               vel_fy = VEL_W'(ema_axis(longint'(vel_fy), ry, a, seeded));
               seeded = 1'b1;
            end
         end
         est.pos_x_mm  = pos_to_out(f.meas_x);
         est.pos_y_mm  = pos_to_out(f.meas_y);
         est.vel_x_mms = vel_to_out(vel_fx);
         est.vel_y_mms = vel_to_out(vel_fy);
         est.detected  = 1'b1;
         pending_estimates.push_back(est);
         last_x   = f.meas_x;
         last_y   = f.meas_y;
         pos_seen = 1'b1;
      end else begin
         if (misses != MISS_MAX)
            misses++;
         if (misses >= lost_after) begin
            // ball lost: publish zeros, keep the filter value but drop its seed
            est = '0;
            pending_estimates.push_back(est);
            pos_seen = 1'b0;
            seeded   = 1'b0;
         end
      end
      last_time = f.frame_time;
      time_seen = 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------------------

   // Mostly short pauses, now and then a long one
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_payload_type make_frame(input bit found, input int x, input int y,
                                                  input logic [TIME_W-1:0] t);
      req_payload_type f;
      f.ball_found = found;
      f.meas_x     = x[POS_W-1:0];
      f.meas_y     = y[POS_W-1:0];
      f.frame_time = t;
      return f;
   endfunction

   // Offer one frame, hold it until taken, then predict it and maybe pause.
   task automatic offer_frame(input req_payload_type f);
      int gap;
      req_if.valid      <= 1'b1;
      req_if.ball_found <= f.ball_found;
      req_if.meas_x     <= f.meas_x;
      req_if.meas_y     <= f.meas_y;
      req_if.frame_time <= f.frame_time;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      estimate_frame(f);
      gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_idle() : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain every expected estimate, then let a frame that publishes nothing finish.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back while the block is idle.
   task automatic configure(input logic [CSR_W-1:0] alpha, input logic [CSR_W-1:0] max_gap,
                            input logic [CSR_W-1:0] limit);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_ALPHA;
      csr_wdata <= alpha;
      @(posedge clock);
      alpha_cfg = alpha[ALPHA_W-1:0];
      csr_index <= CSR_MAX_GAP;
      csr_wdata <= max_gap;
      @(posedge clock);
      gap_limit = max_gap;
      csr_index <= CSR_MISS_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      lost_after = limit[LIMIT_W-1:0];
      csr_we <= 1'b0;
   endtask

   // Random frames: mostly a moving ball with plausible gaps, plus miss bursts,
   // repeated stamps, gaps outside the window and pure noise.
   task automatic random_frames(input int count);
      int left, r, burst, span, mag;
      logic [TIME_W-1:0] dt;
      left = count;
      track_time = $urandom;
      while (left > 0) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            burst = $urandom_range(1, int'(lost_after) + 2);
            repeat (burst) begin
               track_time += $urandom_range(101, 30000);
               offer_frame(make_frame(1'b0, $urandom, $urandom, track_time));
            end
            left -= burst;
         end else if (r < 18) begin
            // repeated stamp: ignored, so it does not count
            offer_frame(make_frame($urandom_range(0, 1), $urandom, $urandom, track_time));
         end else if (r < 22) begin
            offer_frame(make_frame($urandom_range(0, 1), $urandom, $urandom, $urandom));
            left--;
         end else begin
            if (r < 28)
               dt = $urandom_range(1, 100);
            else if (r < 32)
               dt = gap_limit + $urandom_range(1, 1000);
            else if (r < 35)
               dt = gap_limit;
            else begin
               span = (gap_limit - 101 > 40000) ? 40000 : int'(gap_limit - 101);
               dt = 101 + $urandom_range(0, span);
            end
            track_time += dt;
            if ($urandom_range(0, 49) == 0) begin
               track_x = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
               track_y = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
            end else begin
               mag = 1 << $urandom_range(0, 14);
               track_x += int'($urandom_range(0, 2 * mag)) - mag;
               mag = 1 << $urandom_range(0, 14);
               track_y += int'($urandom_range(0, 2 * mag)) - mag;
            end
            if (track_x > POS_MAX) track_x = POS_MAX;
            if (track_x < POS_MIN) track_x = POS_MIN;
            if (track_y > POS_MAX) track_y = POS_MAX;
            if (track_y < POS_MIN) track_y = POS_MIN;
            offer_frame(make_frame(1'b1, track_x, track_y, track_time));
            left--;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Result side: stalls, hold-off and checking
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_off_seen = hold_off_reqs;
         hold_left  = 0;
         stall_left = 0;
      end else if (hold_off_seen != hold_off_reqs) begin
         // long hold-off: let the block fill up and push back on its input
         hold_off_seen = hold_off_reqs;
         hold_left = HOLD_OFF_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         stall_left = pick_idle() - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   function automatic void check_field(input string field, input logic signed [OUT_W-1:0] want,
                                       input logic signed [OUT_W-1:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_estimates.size() == 0) begin
            failures++;
            $display({"%0t: unexpected estimate, expected none, ",
                      "actual pos %0d/%0d vel %0d/%0d det %0b"},
                     $time, rsp_if.pos_x_mm, rsp_if.pos_y_mm, rsp_if.vel_x_mms,
                     rsp_if.vel_y_mms, rsp_if.detected);
         end else begin
            want = pending_estimates.pop_front();
            check_field("pos_x_mm",  want.pos_x_mm,  rsp_if.pos_x_mm);
            check_field("pos_y_mm",  want.pos_y_mm,  rsp_if.pos_y_mm);
            check_field("vel_x_mms", want.vel_x_mms, rsp_if.vel_x_mms);
            check_field("vel_y_mms", want.vel_y_mms, rsp_if.vel_y_mms);
            check_field("detected",  OUT_W'(want.detected), OUT_W'(rsp_if.detected));
         end
      end
   end

   // Count cycles with no handshake and no register write; give up past the limit.
   always @(posedge clock) begin
      if (reset || csr_we || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("ball_velocity_estimator test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Default registers: field extremes, the gap window edges, loss and recovery, wrap.
   task automatic test_directed_defaults();
      int k;
      offer_frame(make_frame(1'b1, POS_MAX, POS_MIN, 32'd0));      // no history yet
      offer_frame(make_frame(1'b1, 5, 5, 32'd0));                  // repeated stamp
      offer_frame(make_frame(1'b1, POS_MIN, POS_MAX, 32'd101));    // narrowest gap, seeds
      offer_frame(make_frame(1'b1, 0, 0, 32'd201));                // gap of 100: keep
      offer_frame(make_frame(1'b1, 160, -160, 32'd100201));        // gap equal to the limit
      offer_frame(make_frame(1'b1, 1600, 800, 32'd200202));        // just over the limit
      offer_frame(make_frame(1'b1, -1, -17, 32'd210202));          // truncate toward zero
      for (k = 1; k <= 6; k++)                                      // last two declare loss
         offer_frame(make_frame(1'b0, POS_MAX, POS_MIN, 32'd210202 + k * 1000));
      offer_frame(make_frame(1'b0, 0, 0, 32'd216202));             // repeat during misses
      offer_frame(make_frame(1'b1, 320, 320, 32'd220000));         // hit without history
      offer_frame(make_frame(1'b1, 480, 160, 32'd230000));         // reseed after loss
      offer_frame(make_frame(1'b1, -480, 32, 32'hFFFF_FF00));      // gap too wide
      offer_frame(make_frame(1'b1, -320, 64, 32'h0000_0100));      // gap wraps past zero
      offer_frame(make_frame(1'b0, 0, 0, 32'h0000_0200));
      offer_frame(make_frame(1'b1, 0, 0, 32'h0000_0400));          // single miss forgotten
   endtask

   // Extreme register values, including alpha above one and a miss limit of zero.
   task automatic test_register_extremes();
      configure(32'(ALPHA_ONE), 32'd101, 32'd1);
      random_frames(120);
      configure(32'd0, 32'hFFFF_FFFF, 32'd15);
      random_frames(120);
      configure(32'h0001_FFFF, 32'(GAP_RESET), 32'd0);
      random_frames(120);
      configure(32'(ALPHA_RESET), 32'(GAP_RESET), 32'(LIMIT_RESET));
      random_frames(60);
   endtask

   // No idling on either side.
   task automatic test_back_to_back();
      wait_idle();
      idle_on = 1'b0;
      random_frames(100);
      idle_on = 1'b1;
   endtask

   // Hold the result side off while frames keep coming.
   task automatic test_backpressure();
      wait_idle();
      idle_on = 1'b0;
      hold_off_reqs++;
      random_frames(60);
      idle_on = 1'b1;
   endtask

   // Random register settings, each followed by a stretch of random tracking.
   task automatic test_random_tracking();
      int phase;
      logic [CSR_W-1:0] max_gap;
      for (phase = 0; phase < 9; phase++) begin
         case ($urandom_range(0, 2))
            0:       max_gap = 101 + $urandom_range(0, 400);
            1:       max_gap = $urandom_range(1000, 200000);
            default: max_gap = $urandom;
         endcase
         if (max_gap < 101)
            max_gap = 101;
         configure($urandom_range(0, 65536), max_gap, $urandom_range(1, 15));
         random_frames(120);
      end
   endtask

   initial begin
      idle_on      = 1'b1;
      alpha_cfg    = ALPHA_RESET;
      gap_limit    = GAP_RESET;
      lost_after   = LIMIT_RESET;
      last_x       = '0;
      last_y       = '0;
      last_time    = '0;
      time_seen    = 1'b0;
      pos_seen     = 1'b0;
      seeded       = 1'b0;
      vel_fx       = '0;
      vel_fy       = '0;
      misses       = '0;
      track_x      = 0;
      track_y      = 0;
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= CSR_ALPHA;
      csr_wdata    <= '0;
      req_if.valid      <= 1'b0;
      req_if.ball_found <= 1'b0;
      req_if.meas_x     <= '0;
      req_if.meas_y     <= '0;
      req_if.frame_time <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_defaults();
      test_register_extremes();
      test_back_to_back();
      test_backpressure();
      test_random_tracking();

      wait_idle();
      if (failures == 0)
         $display("ball_velocity_estimator test passed");
      else
         $display("ball_velocity_estimator test failed");
      $finish;
   end

endmodule
